// ===== design/ffpd_pkg.sv =====
// Shared types and constants for the form field percent decoder.
// Used by every module of the block; depends on nothing.
package ffpd_pkg;

	// most results that one input byte can cause
	localparam int unsigned MAX_RES = 4;

	// result status codes
	localparam logic [1:0] ST_BYTE     = 2'd0;
	localparam logic [1:0] ST_FINISHED = 2'd1;
	localparam logic [1:0] ST_NO_KEY   = 2'd2;

	// special characters
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_AMP     = 8'h26;
	localparam logic [7:0] CH_SPACE   = 8'h20;

	// offsets from ascii to hex digit value
	localparam logic [7:0] HEX_DEC_OFS   = 8'd48;
	localparam logic [7:0] HEX_UPPER_OFS = 8'd55;
	localparam logic [7:0] HEX_LOWER_OFS = 8'd87;

	typedef enum logic [1:0] {
		PH_SEARCH = 2'd0,
		PH_VALUE  = 2'd1,
		PH_ESC    = 2'd2,
		PH_DONE   = 2'd3
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] status;
		logic       last;
	} out_item_t;

	// all results of one input byte, item 0 goes out first
	typedef struct packed {
		logic [2:0]                  n;
		out_item_t [MAX_RES-1:0]     item;
	} grp_t;

	// queue status seen by front and back
	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

endpackage

// ===== design/ffpd_front.sv =====
// Front part: key search, escape handling and result grouping per input byte.
// Depends on ffpd_pkg; feeds ffpd_group_fifo.
module ffpd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              text_valid,
	input  ffpd_pkg::in_item_t text,
	input  ffpd_pkg::q_stat_t  q_stat,
	output logic              push,
	output ffpd_pkg::grp_t    push_grp
);

	// "data=" with the first character at index 0
	localparam logic [4:0][7:0] KEY = {8'h3D, 8'h61, 8'h74, 8'h61, 8'h64};
	localparam logic [2:0] KEY_LEN = 3'd5;

	typedef struct packed {
		ffpd_pkg::phase_t ph;
		logic             hc;
		logic [7:0]       h0;
		logic             emit;
		logic [7:0]       eb;
	} step_t;

	// {digit ok, value}
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [7:0] d;
		begin
			d = 8'd0;
			hex_value = 5'd0;
			if (c >= 8'h30 && c <= 8'h39) begin
				d = c - ffpd_pkg::HEX_DEC_OFS;
				hex_value = {1'b1, d[3:0]};
			end else if (c >= 8'h41 && c <= 8'h46) begin
				d = c - ffpd_pkg::HEX_UPPER_OFS;
				hex_value = {1'b1, d[3:0]};
			end else if (c >= 8'h61 && c <= 8'h66) begin
				d = c - ffpd_pkg::HEX_LOWER_OFS;
				hex_value = {1'b1, d[3:0]};
			end
		end
	endfunction

	// one value byte outside of a pending two digit escape
	function automatic step_t feed_simple(input step_t s_in, input logic [7:0] b);
		step_t s;
		begin
			s = s_in;
			s.emit = 1'b0;
			s.eb = 8'd0;
			case (s.ph)
				ffpd_pkg::PH_VALUE: begin
					if (b == ffpd_pkg::CH_PERCENT) begin
						s.ph = ffpd_pkg::PH_ESC;
						s.hc = 1'b0;
					end else if (b == ffpd_pkg::CH_PLUS) begin
						s.emit = 1'b1;
						s.eb = ffpd_pkg::CH_SPACE;
					end else if (b == ffpd_pkg::CH_AMP) begin
						s.ph = ffpd_pkg::PH_DONE;
					end else begin
						s.emit = 1'b1;
						s.eb = b;
					end
				end
				ffpd_pkg::PH_ESC: begin
					s.h0 = b;
					s.hc = 1'b1;
				end
				default: begin
				end
			endcase
			feed_simple = s;
		end
	endfunction

	ffpd_pkg::phase_t phase_q;
	logic [2:0]       kmc_q;
	logic             hc_q;
	logic [7:0]       h0_q;

	logic             accept;
	step_t            st;
	step_t            st_h;
	step_t            st_b;
	logic [2:0]       k;
	logic [2:0]       n;
	logic [4:0]       hi;
	logic [4:0]       lo;
	ffpd_pkg::grp_t   grp;
	ffpd_pkg::phase_t phase_d;
	logic [2:0]       kmc_d;
	logic             hc_d;
	logic [7:0]       h0_d;

	assign accept = text_valid && !q_stat.full;

	// per byte decision and result list
	always_comb begin
		st = '{ph: phase_q, hc: hc_q, h0: h0_q, emit: 1'b0, eb: 8'd0};
		st_h = st;
		st_b = st;
		k = kmc_q;
		n = 3'd0;
		grp = '0;
		hi = hex_value(h0_q);
		lo = hex_value(text.in_byte);

		if (phase_q == ffpd_pkg::PH_SEARCH) begin
			if (k > 3'd4)
				k = 3'd0;
			if (text.in_byte == KEY[k]) begin
				k = k + 3'd1;
				if (k == KEY_LEN) begin
					st.ph = ffpd_pkg::PH_VALUE;
					k = 3'd0;
				end
			end else begin
				k = (text.in_byte == KEY[0]) ? 3'd1 : 3'd0;
			end
		end else if (phase_q == ffpd_pkg::PH_ESC && hc_q) begin
			// second escape digit arrives
			st.ph = ffpd_pkg::PH_VALUE;
			st.hc = 1'b0;
			if (hi[4] && lo[4]) begin
				grp.item[n[1:0]].out_byte = {hi[3:0], lo[3:0]};
				n = n + 3'd1;
			end else begin
				// bad escape: literal percent, then both bytes again
				grp.item[n[1:0]].out_byte = ffpd_pkg::CH_PERCENT;
				n = n + 3'd1;
				st_h = feed_simple(st, h0_q);
				if (st_h.emit) begin
					grp.item[n[1:0]].out_byte = st_h.eb;
					n = n + 3'd1;
				end
				st_b = feed_simple(st_h, text.in_byte);
				if (st_b.emit) begin
					grp.item[n[1:0]].out_byte = st_b.eb;
					n = n + 3'd1;
				end
				st = st_b;
			end
		end else begin
			st_b = feed_simple(st, text.in_byte);
			if (st_b.emit) begin
				grp.item[n[1:0]].out_byte = st_b.eb;
				n = n + 3'd1;
			end
			st = st_b;
		end

		phase_d = st.ph;
		kmc_d = k;
		hc_d = st.hc;
		h0_d = st.h0;

		// end of text: flush a short escape, then the closing status
		if (text.end_of_text) begin
			if (st.ph == ffpd_pkg::PH_ESC) begin
				grp.item[n[1:0]].out_byte = ffpd_pkg::CH_PERCENT;
				n = n + 3'd1;
				if (st.hc) begin
					grp.item[n[1:0]].out_byte = st.h0;
					n = n + 3'd1;
				end
			end
			grp.item[n[1:0]].status = (st.ph == ffpd_pkg::PH_SEARCH) ?
				ffpd_pkg::ST_NO_KEY : ffpd_pkg::ST_FINISHED;
			n = n + 3'd1;
			phase_d = ffpd_pkg::PH_SEARCH;
			kmc_d = 3'd0;
			hc_d = 1'b0;
			h0_d = 8'd0;
		end

		// mark the final result of this byte
		if (n != 3'd0)
			grp.item[n[1:0] - 2'd1].last = 1'b1;
		grp.n = n;
	end

	assign push = accept && (n != 3'd0);
	assign push_grp = grp;

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ffpd_pkg::PH_SEARCH;
			kmc_q <= 3'd0;
			hc_q <= 1'b0;
			h0_q <= 8'd0;
		end else if (accept) begin
			phase_q <= phase_d;
			kmc_q <= kmc_d;
			hc_q <= hc_d;
			h0_q <= h0_d;
		end
	end

	// a held digit only exists inside an escape
	a_held_in_esc: assert property (@(posedge clk) disable iff (!arst_n)
		hc_q |-> phase_q == ffpd_pkg::PH_ESC)
		else $error("held digit outside escape");

	// end of text brings the decoder back to key search
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		accept && text.end_of_text |=> phase_q == ffpd_pkg::PH_SEARCH && kmc_q == 3'd0)
		else $error("state not cleared after end of text");

	// a pushed group holds one to four results
	a_grp_size: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_grp.n != 3'd0 && (!push_grp.n[2] || push_grp.n[1:0] == 2'd0))
		else $error("bad result group size");

endmodule

// ===== design/ffpd_group_fifo.sv =====
// Short queue of result groups between front and back parts.
// Depends on ffpd_pkg.
module ffpd_group_fifo #(
	parameter int unsigned DEPTH = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ffpd_pkg::grp_t    push_grp,
	input  logic              pop,
	output ffpd_pkg::grp_t    head_grp,
	output ffpd_pkg::q_stat_t q_stat
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	ffpd_pkg::grp_t   entry_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign q_stat.full = (count_q == CNT_FULL);
	assign q_stat.nonempty = (count_q != '0);
	assign head_grp = entry_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_grp;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	// no overflow, no underflow
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> q_stat.nonempty)
		else $error("pop from empty queue");

endmodule

// ===== design/ffpd_back.sv =====
// Back part: sends the results of each queued group one per transfer.
// Depends on ffpd_pkg; reads the head of ffpd_group_fifo.
module ffpd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  ffpd_pkg::q_stat_t   q_stat,
	input  ffpd_pkg::grp_t      head_grp,
	output logic                pop,
	output logic                res_valid,
	input  logic                res_stall,
	output ffpd_pkg::out_item_t res
);

	logic                valid_q;
	ffpd_pkg::out_item_t res_q;
	logic [1:0]          idx_q;
	logic                load;
	logic                at_end;

	// load the output register whenever a group waits and the register is empty or being taken
	assign load = q_stat.nonempty && (!valid_q || !res_stall);
	assign at_end = ({1'b0, idx_q} == head_grp.n - 3'd1);
	assign pop = load && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
			end else if (!res_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (load)
			res_q <= head_grp.item[idx_q];
	end

	assign res_valid = valid_q;
	assign res = res_q;

endmodule

// ===== design/form_field_percent_decoder.sv =====
// Form field percent decoder, top level.
// Channel "text" takes one request byte per transfer with an end of text flag.
// Channel "res" gives decoded bytes, then one closing status per text
// (finished, or key "data=" not found); last marks the final result of a byte.
// Both channels use valid/stall: a transfer happens when valid is high and
// stall is low. A text byte causes zero to four results.
// A transferred byte's results are written into the queue, then loaded from
// its head into the output register on res. Throughput is one byte per cycle
// while each byte causes at most one result and res_stall is low; results
// leave at one per cycle while res_stall is low, so a byte with n results
// takes n transfers on res. The queue of QUEUE_DEPTH result groups sets how
// far the input can run ahead; text_stall rises when it is full. When res_stall
// is high the output register holds its result and the queue fills; the front
// keeps accepting until the queue is full. Reset clears the search state, the
// queue and the output valid; the block then waits for the first byte of a
// new text. Depends on ffpd_pkg, ffpd_front, ffpd_group_fifo and ffpd_back.
module form_field_percent_decoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                text_valid,
	output logic                text_stall,
	input  ffpd_pkg::in_item_t  text,
	output logic                res_valid,
	input  logic                res_stall,
	output ffpd_pkg::out_item_t res
);

	ffpd_pkg::q_stat_t q_stat;
	ffpd_pkg::grp_t    push_grp;
	ffpd_pkg::grp_t    head_grp;
	logic              push;
	logic              pop;

	assign text_stall = q_stat.full;

	ffpd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text_valid(text_valid),
		.text      (text),
		.q_stat    (q_stat),
		.push      (push),
		.push_grp  (push_grp)
	);

	ffpd_group_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_grp(push_grp),
		.pop     (pop),
		.head_grp(head_grp),
		.q_stat  (q_stat)
	);

	ffpd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.head_grp (head_grp),
		.pop      (pop),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res      (res)
	);

endmodule
